// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/stq_pkg.sv =====
// Types and codes shared by the sorted task queue modules.
package stq_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_POP    = 2'd2,
    ACT_ROTATE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] pid;
    logic [31:0] arrival;
    logic [15:0] run_time;
  } entry_t;

  typedef struct packed {
    logic    upd;
    action_e act;
    entry_t  item;
    entry_t  front;
  } cell_ctrl_t;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned TotalW   = 5;

endpackage

// ===== hdl/stq_cell.sv =====
// One queue slot: holds an entry, compares it with a new request and shifts with its neighbours.
module stq_cell
  import stq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cap_i,
  input  action_e    cap_act_i,
  input  entry_t     cap_item_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     left_entry_i,
  input  logic       left_valid_i,
  input  logic       left_found_i,
  input  entry_t     right_entry_i,
  input  logic       right_valid_i,
  output entry_t     entry_o,
  output logic       valid_o,
  output logic       found_o,
  output entry_t     next_entry_o,
  output logic       next_valid_o
);

  entry_t entry_q, entry_d;
  logic   valid_q, valid_d;
  logic   hit_q, hit_d;

  function automatic logic goes_ahead(entry_t a, entry_t b);
    if (a.arrival != b.arrival) begin
      return a.arrival < b.arrival;
    end
    return a.run_time <= b.run_time;
  endfunction

  always_comb begin
    hit_d = hit_q;
    if (cap_i) begin
      if (cap_act_i == ACT_APPEND) begin
        hit_d = !valid_q;
      end else begin
        hit_d = !valid_q || goes_ahead(cap_item_i, entry_q);
      end
    end
  end

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.upd) begin
      case (ctrl_i.act)
        ACT_INSERT, ACT_APPEND: begin
          if (left_found_i) begin
            entry_d = left_entry_i;
            valid_d = left_valid_i;
          end else if (hit_q) begin
            entry_d = ctrl_i.item;
            valid_d = 1'b1;
          end
        end
        ACT_POP: begin
          entry_d = right_entry_i;
          valid_d = right_valid_i;
        end
        ACT_ROTATE: begin
          if (right_valid_i) begin
            entry_d = right_entry_i;
          end else if (valid_q) begin
            entry_d = ctrl_i.front;
          end
        end
        default: begin
          entry_d = entry_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o      = entry_q;
  assign valid_o      = valid_q;
  assign found_o      = left_found_i || hit_q;
  assign next_entry_o = entry_d;
  assign next_valid_o = valid_d;

endmodule

// ===== hdl/sorted_task_queue_top.sv =====
// Sorted task queue built as a row of shifting slot cells.
//
//  channel  | dir | tdata fields (lowest bit up)
//  s_axis   | in  | action, task_pid, task_arrival, task_time
//  m_axis   | out | status, head_valid, head_pid, head_arrival, head_time, entry_total
//
// Each request first has its per-cell compare registered as it is taken, then shifts the row.
// A new request is taken once the row update of the previous one is done.
// The result register frees the input side; a stalled result holds the row update back.
// Reset empties the queue at once; slot contents are only read below the fill level.
module sorted_task_queue_top
  import stq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // action, task_pid, task_arrival, task_time
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // status, head_valid, head_pid, head_arrival,
                                              // head_time, entry_total
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  action_e in_act;
  entry_t  in_item;
  logic    accept;
  logic    fire;

  logic            busy_q, busy_d;
  action_e         act_q;
  entry_t          item_q;
  logic [CntW-1:0] count_q, count_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  entry_t     entry_w      [QUEUE_DEPTH];
  logic       valid_w      [QUEUE_DEPTH];
  logic       found_w      [QUEUE_DEPTH];
  entry_t     next_entry_w [QUEUE_DEPTH];
  logic       next_valid_w [QUEUE_DEPTH];
  cell_ctrl_t ctrl;
  logic       full;
  logic       empty;
  status_e    status;
  entry_t     head;

  assign in_act          = action_e'(s_axis_tdata[1:0]);
  assign in_item.pid      = s_axis_tdata[17:2];
  assign in_item.arrival  = s_axis_tdata[49:18];
  assign in_item.run_time = s_axis_tdata[65:50];

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = busy_q && (!out_valid_q || m_axis_tready);

  assign full  = valid_w[QUEUE_DEPTH-1];
  assign empty = !valid_w[0];

  always_comb begin
    status = ST_DONE;
    case (act_q)
      ACT_INSERT, ACT_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end
      end
      ACT_POP, ACT_ROTATE: begin
        if (empty) begin
          status = ST_EMPTY;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  assign ctrl.upd   = fire && (status == ST_DONE);
  assign ctrl.act   = act_q;
  assign ctrl.item  = item_q;
  assign ctrl.front = entry_w[0];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t l_entry, r_entry;
    logic   l_valid, l_found, r_valid;
    if (i == 0) begin : g_first
      assign l_entry = '0;
      assign l_valid = 1'b0;
      assign l_found = 1'b0;
    end else begin : g_mid
      assign l_entry = entry_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_found = found_w[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_entry = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_entry = entry_w[i+1];
      assign r_valid = valid_w[i+1];
    end
    stq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cap_i        (accept),
      .cap_act_i    (in_act),
      .cap_item_i   (in_item),
      .ctrl_i       (ctrl),
      .left_entry_i (l_entry),
      .left_valid_i (l_valid),
      .left_found_i (l_found),
      .right_entry_i(r_entry),
      .right_valid_i(r_valid),
      .entry_o      (entry_w[i]),
      .valid_o      (valid_w[i]),
      .found_o      (found_w[i]),
      .next_entry_o (next_entry_w[i]),
      .next_valid_o (next_valid_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.upd) begin
      case (act_q)
        ACT_INSERT, ACT_APPEND: count_d = count_q + CntW'(1);
        ACT_POP:                count_d = count_q - CntW'(1);
        default:                count_d = count_q;
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (fire) begin
      busy_d = 1'b0;
    end
  end

  assign head = next_valid_w[0] ? next_entry_w[0] : '0;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (fire) begin
      out_valid_d = 1'b1;
      out_data_d  = {TotalW'(count_d), head.run_time, head.arrival, head.pid,
                     next_valid_w[0], status};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= in_act;
      item_q <= in_item;
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/stq_checker.sv =====
// Port-level checks for the sorted task queue and their binding to the top level.
`include "assert_macros.svh"

module stq_checker
  import stq_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic    req_taken;
  status_e res_status;
  logic    res_head_valid;
  logic    res_total_nz;
  logic    res_head_zero;

  assign req_taken      = s_axis_tvalid && s_axis_tready;
  assign res_status     = status_e'(m_axis_tdata[1:0]);
  assign res_head_valid = m_axis_tdata[2];
  assign res_total_nz   = m_axis_tdata[71:67] != '0;
  assign res_head_zero  = m_axis_tdata[66:3] == '0;

  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_taken, !s_axis_tready, "second request taken while busy")
  `ASSERT_IMPL(a_empty_no_head, clk_i, rst_ni, m_axis_tvalid && (res_status == ST_EMPTY), !res_head_valid && !res_total_nz, "empty status with a head")
  `ASSERT_IMPL(a_full_has_head, clk_i, rst_ni, m_axis_tvalid && (res_status == ST_FULL), res_head_valid, "full status without a head")
  `ASSERT_IMPL(a_idle_head_zero, clk_i, rst_ni, m_axis_tvalid && !res_head_valid, res_head_zero && !res_total_nz, "empty queue with head fields set")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind sorted_task_queue_top stq_checker u_stq_checker (.*);

// ===== tb/sorted_task_queue_checker.sv =====
// Checker for the sorted task queue: predicts each result from the accepted requests and compares.
module sorted_task_queue_checker
  import stq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int                  error_count_o,
  output int                  open_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e           status;
    logic              head_valid;
    entry_t            head;
    logic [TotalW-1:0] total;
  } head_report_t;

  entry_t       task_list[$];
  head_report_t awaited_reports[$];
  int           errors = 0;

  assign error_count_o = errors;

  initial open_count_o = 0;

  function automatic bit runs_ahead(entry_t fresh, entry_t held);
    if (fresh.arrival != held.arrival) begin
      return fresh.arrival < held.arrival;
    end
    return fresh.run_time <= held.run_time;
  endfunction

  function automatic head_report_t apply_action(action_e act, entry_t item);
    head_report_t rep;
    int           pos;
    bit           found;
    entry_t       front;
    rep.status = ST_DONE;
    case (act)
      ACT_INSERT, ACT_APPEND: begin
        if (task_list.size() >= QUEUE_DEPTH) begin
          rep.status = ST_FULL;
        end else if (act == ACT_APPEND) begin
          task_list.push_back(item);
        end else begin
          pos   = task_list.size();
          found = 1'b0;
          for (int i = 0; i < task_list.size(); i++) begin
            if (!found && runs_ahead(item, task_list[i])) begin
              pos   = i;
              found = 1'b1;
            end
          end
          task_list.insert(pos, item);
        end
      end
      default: begin
        if (task_list.size() == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          front = task_list.pop_front();
          if (act == ACT_ROTATE) begin
            task_list.push_back(front);
          end
        end
      end
    endcase
    if (task_list.size() != 0) begin
      rep.head_valid = 1'b1;
      rep.head       = task_list[0];
    end else begin
      rep.head_valid = 1'b0;
      rep.head       = '0;
    end
    rep.total = TotalW'(task_list.size());
    return rep;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    head_report_t want;
    entry_t       item;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_reports.size() == 0) begin
          errors++;
          $display("%0t: result %0h expected none got one", $time, m_axis_tdata);
        end else begin
          want = awaited_reports.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tdata[1:0]));
          check_field("head_valid", 32'(want.head_valid), 32'(m_axis_tdata[2]));
          check_field("head_pid", 32'(want.head.pid), 32'(m_axis_tdata[18:3]));
          check_field("head_arrival", want.head.arrival, m_axis_tdata[50:19]);
          check_field("head_time", 32'(want.head.run_time), 32'(m_axis_tdata[66:51]));
          check_field("entry_total", 32'(want.total), 32'(m_axis_tdata[71:67]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        item.pid      = s_axis_tdata[17:2];
        item.arrival  = s_axis_tdata[49:18];
        item.run_time = s_axis_tdata[65:50];
        awaited_reports.push_back(apply_action(action_e'(s_axis_tdata[1:0]), item));
      end
      open_count_o <= awaited_reports.size();
    end
  end

endmodule

// ===== tb/sorted_task_queue_top_test.sv =====
// Testbench top for the sorted task queue: clock, reset, request stimulus and verdict.
module sorted_task_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int          RANDOM_ITEMS = 1500;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  bit tx_calm    = 1'b0;
  bit rx_calm    = 1'b0;
  int stall_left = 0;
  int error_count;
  int open_count;

  always #5 clk_i = ~clk_i;

  sorted_task_queue_top #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  sorted_task_queue_checker #(
    .QUEUE_DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .error_count_o(error_count),
    .open_count_o (open_count)
  );

  // stall the result side now and then, mostly briefly
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic entry_t make_entry(logic [15:0] pid, logic [31:0] arrival,
                                        logic [15:0] run_time);
    entry_t e;
    e.pid      = pid;
    e.arrival  = arrival;
    e.run_time = run_time;
    return e;
  endfunction

  function automatic entry_t random_entry();
    entry_t e;
    int     pick;
    pick  = $urandom_range(0, 9);
    e.pid = 16'($urandom);
    if (pick < 4) begin
      e.arrival  = $urandom_range(0, 7);
      e.run_time = 16'($urandom_range(0, 3));
    end else if (pick == 4) begin
      e.arrival  = $urandom_range(0, 1) ? '1 : '0;
      e.run_time = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      e.arrival  = $urandom;
      e.run_time = 16'($urandom);
    end
    return e;
  endfunction

  task automatic send_request(action_e act, entry_t item);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, item.run_time, item.arrival, item.pid, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (tx_calm) begin
      gap = 0;
    end else begin
      gap = $urandom_range(0, 99);
      gap = (gap < 70) ? 0 : (gap < 95) ? $urandom_range(1, 3) : $urandom_range(15, 60);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int      sent;
    int      run_len;
    int      bias;
    int      add_pct;
    int      waited;
    action_e act;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(ACT_POP, random_entry());
    send_request(ACT_ROTATE, random_entry());
    send_request(ACT_INSERT, make_entry('1, '1, '1));
    send_request(ACT_ROTATE, random_entry());
    send_request(ACT_POP, random_entry());
    // fill to the brim: ties, extremes and appends out of order
    send_request(ACT_INSERT, make_entry(16'h0001, 32'd100, 16'd5));
    send_request(ACT_INSERT, make_entry(16'h0002, 32'd100, 16'd5));
    send_request(ACT_INSERT, make_entry(16'h0003, 32'd100, 16'd3));
    send_request(ACT_INSERT, make_entry(16'h0004, 32'd100, 16'd9));
    send_request(ACT_INSERT, make_entry(16'h0005, 32'd50, 16'd60000));
    send_request(ACT_APPEND, make_entry(16'h0006, 32'd0, 16'd0));
    send_request(ACT_INSERT, make_entry('0, '0, '0));
    send_request(ACT_INSERT, make_entry('1, '1, '1));
    send_request(ACT_INSERT, make_entry('1, '1, '1));
    send_request(ACT_APPEND, make_entry(16'hAAAA, 32'h5555_5555, 16'hAAAA));
    send_request(ACT_INSERT, make_entry(16'h5555, 32'hAAAA_AAAA, 16'h5555));
    send_request(ACT_INSERT, make_entry(16'h1234, 32'd100, 16'd0));
    send_request(ACT_APPEND, make_entry(16'h0007, 32'd200, 16'd1));
    send_request(ACT_INSERT, make_entry(16'h0008, 32'd99, '1));
    send_request(ACT_INSERT, make_entry(16'h0009, 32'd101, 16'd0));
    send_request(ACT_INSERT, make_entry(16'h000A, 32'd0, 16'd1));
    send_request(ACT_INSERT, random_entry());
    send_request(ACT_APPEND, random_entry());
    send_request(ACT_ROTATE, random_entry());
    send_request(ACT_POP, random_entry());

    // runs that lean towards filling, draining or neither
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      run_len = $urandom_range(20, 80);
      bias    = $urandom_range(0, 2);
      add_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 99) < add_pct) begin
          act = ($urandom_range(0, 9) < 7) ? ACT_INSERT : ACT_APPEND;
        end else begin
          act = $urandom_range(0, 1) ? ACT_POP : ACT_ROTATE;
        end
        send_request(act, random_entry());
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    // let the count of the last accepted request settle before polling it
    @(posedge clk_i);
    waited = 0;
    while (open_count != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && open_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
